### src/tqs_pkg.sv
// Shared types, constants and reference lattice tables for the triangle quadrature sampler.
`timescale 1ns / 1ps
`default_nettype none
package tqs_pkg;

  localparam int RESOLUTION = 8;
  localparam int STEPS      = (RESOLUTION > 1) ? RESOLUTION - 1 : 1;
  localparam int NODES      = RESOLUTION * (RESOLUTION + 1) / 2;
  localparam int IDX_W      = $clog2(NODES);

  localparam int IN_W   = 192;
  localparam int OUT_W  = 96;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam int EDGE_W = 33;
  localparam int MUL_W  = 34;
  localparam int PROD_W = 68;

  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 29;
  localparam int CNT_W      = 5;

  // register index, taken from paddr[2]
  localparam logic REG_GEOMETRY_MODE = 1'b0;

  typedef logic [31:0] tab_t [NODES];

  function automatic tab_t build_ref_x();
    tab_t t;
    int   i;
    i = 0;
    for (int r = 0; r < RESOLUTION; r++) begin
      for (int j = 0; j < RESOLUTION - r; j++) begin
        t[i] = 32'((longint'(j) * (longint'(1) << 29) + STEPS) / (2 * STEPS));
        i++;
      end
    end
    return t;
  endfunction

  function automatic tab_t build_ref_y();
    tab_t t;
    int   i;
    i = 0;
    for (int r = 0; r < RESOLUTION; r++) begin
      for (int j = 0; j < RESOLUTION - r; j++) begin
        t[i] = 32'((longint'(r) * (longint'(1) << 29) + STEPS) / (2 * STEPS));
        i++;
      end
    end
    return t;
  endfunction

  function automatic tab_t build_ref_w();
    tab_t t;
    int   cnt [NODES];
    int   i;
    int   w;
    i = 0;
    for (int k = 0; k < NODES; k++) cnt[k] = 0;
    for (int r = 0; r < RESOLUTION; r++) begin
      w = RESOLUTION - r;
      for (int j = 0; j < w; j++) begin
        if (j < w - 1) begin
          cnt[i]++;
          cnt[i + 1]++;
          cnt[i + w]++;
          if (j < w - 2) begin
            cnt[i + 1]++;
            cnt[i + w]++;
            cnt[i + w + 1]++;
          end
        end
        i++;
      end
    end
    for (int k = 0; k < NODES; k++) begin
      t[k] = 32'((longint'(cnt[k]) * (longint'(1) << 33) + 6 * STEPS * STEPS)
                 / (12 * STEPS * STEPS));
    end
    return t;
  endfunction

  localparam tab_t REF_X = build_ref_x();
  localparam tab_t REF_Y = build_ref_y();
  localparam tab_t REF_W = build_ref_w();

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_KSQ0, OP_KSQ1, OP_SUM, OP_KDX_INIT, OP_KDY_INIT,
    OP_DIV_STEP, OP_KDX_END, OP_KDY_END, OP_EDGES, OP_DET0, OP_DET1, OP_DET2,
    OP_DET3, OP_MX0, OP_MX1, OP_SETX, OP_MY0, OP_MY1, OP_SETY, OP_NUM, OP_EW,
    OP_HSQ0, OP_HSQ1, OP_HT, OP_SQRT_STEP, OP_HP, OP_DW_INIT, OP_DW_END,
    OP_PDX_INIT, OP_PDY_INIT, OP_PDX_END, OP_PDY_END, OP_OUT
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_KSQ0, ST_KSQ1, ST_KSUM, ST_KDX_INIT, ST_KDX_RUN, ST_KDX_END,
    ST_KDY_INIT, ST_KDY_RUN, ST_KDY_END, ST_EDGES, ST_DET0, ST_DET1, ST_DET2,
    ST_DET3, ST_MX0, ST_MX1, ST_MXSUM, ST_SETX, ST_MY0, ST_MY1, ST_MYSUM,
    ST_SETY, ST_NUM, ST_EW, ST_HSQ0, ST_HSQ1, ST_HSUM, ST_HT, ST_SQRT, ST_HP,
    ST_DW_INIT, ST_DW_RUN, ST_DW_END, ST_PDX_INIT, ST_PDX_RUN, ST_PDX_END,
    ST_PDY_INIT, ST_PDY_RUN, ST_PDY_END, ST_OUT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic boundary;
    logic wovf;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### src/tqs_ctrl.sv
// Sequencer for the sampler: walks corner conversion, determinant and per-node steps.
`timescale 1ns / 1ps
`default_nettype none
module tqs_ctrl import tqs_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   s_tvalid,
  output logic  s_tready,
  input  wire   hyp,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(NODES - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(SQRT_STEPS - 1);
  localparam logic [1:0]       CORNER_LAST = 2'd2;

  state_t           state, state_next;
  logic [1:0]       corner;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic             is_last;

  assign is_last = (idx == IDX_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      corner <= '0;
      idx    <= '0;
      cnt    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_KDX_RUN || state == ST_KDY_RUN || state == ST_SQRT ||
          state == ST_DW_RUN || state == ST_PDX_RUN || state == ST_PDY_RUN) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (state == ST_IDLE) begin
        corner <= '0;
        idx    <= '0;
      end else begin
        if (state == ST_KDY_END) corner <= corner + 1'b1;
        if (state == ST_OUT && st.out_free) idx <= idx + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (s_tvalid) state_next = hyp ? ST_KSQ0 : ST_EDGES;
      ST_KSQ0:     state_next = ST_KSQ1;
      ST_KSQ1:     state_next = ST_KSUM;
      ST_KSUM:     state_next = ST_KDX_INIT;
      ST_KDX_INIT: state_next = ST_KDX_RUN;
      ST_KDX_RUN:  if (cnt == DIV_LAST) state_next = ST_KDX_END;
      ST_KDX_END:  state_next = ST_KDY_INIT;
      ST_KDY_INIT: state_next = ST_KDY_RUN;
      ST_KDY_RUN:  if (cnt == DIV_LAST) state_next = ST_KDY_END;
      ST_KDY_END:  state_next = (corner == CORNER_LAST) ? ST_EDGES : ST_KSQ0;
      ST_EDGES:    state_next = ST_DET0;
      ST_DET0:     state_next = ST_DET1;
      ST_DET1:     state_next = ST_DET2;
      ST_DET2:     state_next = ST_DET3;
      ST_DET3:     state_next = ST_MX0;
      ST_MX0:      state_next = ST_MX1;
      ST_MX1:      state_next = ST_MXSUM;
      ST_MXSUM:    state_next = ST_SETX;
      ST_SETX:     state_next = ST_MY0;
      ST_MY0:      state_next = ST_MY1;
      ST_MY1:      state_next = ST_MYSUM;
      ST_MYSUM:    state_next = ST_SETY;
      ST_SETY:     state_next = ST_NUM;
      ST_NUM:      state_next = hyp ? ST_HSQ0 : ST_EW;
      ST_EW:       state_next = ST_OUT;
      ST_HSQ0:     state_next = ST_HSQ1;
      ST_HSQ1:     state_next = ST_HSUM;
      ST_HSUM:     state_next = ST_HT;
      ST_HT:       state_next = st.boundary ? ST_OUT : ST_SQRT;
      ST_SQRT:     if (cnt == SQRT_LAST) state_next = ST_HP;
      ST_HP:       state_next = ST_DW_INIT;
      ST_DW_INIT:  state_next = st.wovf ? ST_PDX_INIT : ST_DW_RUN;
      ST_DW_RUN:   if (cnt == DIV_LAST) state_next = ST_DW_END;
      ST_DW_END:   state_next = ST_PDX_INIT;
      ST_PDX_INIT: state_next = ST_PDX_RUN;
      ST_PDX_RUN:  if (cnt == DIV_LAST) state_next = ST_PDX_END;
      ST_PDX_END:  state_next = ST_PDY_INIT;
      ST_PDY_INIT: state_next = ST_PDY_RUN;
      ST_PDY_RUN:  if (cnt == DIV_LAST) state_next = ST_PDY_END;
      ST_PDY_END:  state_next = ST_OUT;
      ST_OUT:      if (st.out_free) state_next = is_last ? ST_IDLE : ST_MX0;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    cmd.idx  = idx;
    cmd.last = is_last;
    unique case (state)
      ST_IDLE:     cmd.op = s_tvalid ? OP_LOAD : OP_NOP;
      ST_KSQ0:     cmd.op = OP_KSQ0;
      ST_KSQ1:     cmd.op = OP_KSQ1;
      ST_KSUM:     cmd.op = OP_SUM;
      ST_KDX_INIT: cmd.op = OP_KDX_INIT;
      ST_KDX_RUN:  cmd.op = OP_DIV_STEP;
      ST_KDX_END:  cmd.op = OP_KDX_END;
      ST_KDY_INIT: cmd.op = OP_KDY_INIT;
      ST_KDY_RUN:  cmd.op = OP_DIV_STEP;
      ST_KDY_END:  cmd.op = OP_KDY_END;
      ST_EDGES:    cmd.op = OP_EDGES;
      ST_DET0:     cmd.op = OP_DET0;
      ST_DET1:     cmd.op = OP_DET1;
      ST_DET2:     cmd.op = OP_DET2;
      ST_DET3:     cmd.op = OP_DET3;
      ST_MX0:      cmd.op = OP_MX0;
      ST_MX1:      cmd.op = OP_MX1;
      ST_MXSUM:    cmd.op = OP_SUM;
      ST_SETX:     cmd.op = OP_SETX;
      ST_MY0:      cmd.op = OP_MY0;
      ST_MY1:      cmd.op = OP_MY1;
      ST_MYSUM:    cmd.op = OP_SUM;
      ST_SETY:     cmd.op = OP_SETY;
      ST_NUM:      cmd.op = OP_NUM;
      ST_EW:       cmd.op = OP_EW;
      ST_HSQ0:     cmd.op = OP_HSQ0;
      ST_HSQ1:     cmd.op = OP_HSQ1;
      ST_HSUM:     cmd.op = OP_SUM;
      ST_HT:       cmd.op = OP_HT;
      ST_SQRT:     cmd.op = OP_SQRT_STEP;
      ST_HP:       cmd.op = OP_HP;
      ST_DW_INIT:  cmd.op = OP_DW_INIT;
      ST_DW_RUN:   cmd.op = OP_DIV_STEP;
      ST_DW_END:   cmd.op = OP_DW_END;
      ST_PDX_INIT: cmd.op = OP_PDX_INIT;
      ST_PDX_RUN:  cmd.op = OP_DIV_STEP;
      ST_PDX_END:  cmd.op = OP_PDX_END;
      ST_PDY_INIT: cmd.op = OP_PDY_INIT;
      ST_PDY_RUN:  cmd.op = OP_DIV_STEP;
      ST_PDY_END:  cmd.op = OP_PDY_END;
      ST_OUT:      cmd.op = st.out_free ? OP_OUT : OP_NOP;
      default:     cmd.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

### src/tqs_dp.sv
// Datapath: shared multiplier, restoring divider, square root unit and output register.
`timescale 1ns / 1ps
`default_nettype none
module tqs_dp import tqs_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  input  wire              hyp,
  input  cmd_t             cmd,
  output stat_t            st,
  input  wire [IN_W-1:0]   s_tdata,
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);

  function automatic logic [32:0] abs33(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = 33'(v);
    return (e < 0) ? 33'(-e) : 33'(e);
  endfunction

  logic signed [31:0]       c0x, c0y, c1x, c1y, c2x, c2y;
  logic signed [31:0]       org_x, org_y;
  logic signed [EDGE_W-1:0] ea_x, ea_y, eb_x, eb_y;
  logic [31:0]              area;
  logic signed [PROD_W-1:0] prod, acc;
  logic signed [31:0]       x, y;
  logic [63:0]              num;
  logic [56:0]              tsq, sq_v, sq_bit;
  logic [57:0]              sq_res;
  logic [63:0]              rem, dd;
  logic [31:0]              dlo, quo;
  logic                     dsign;
  logic [31:0]              wt;
  logic                     sat;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [MUL_W-1:0]  det_ax, det_ay, det_bx, det_by, ref_z, ref_w;
  logic [PROD_W-1:0]        det_mag, det_r;
  logic signed [PROD_W-1:0] pt_sum;
  logic signed [31:0]       pt_clamped, pt_org;
  logic [39:0]              k_den;
  logic [32:0]              k_abs;
  logic [63:0]              k_num;
  logic [29:0]              p_den;
  logic [63:0]              p_num;
  logic [64:0]              div_r2;
  logic                     div_ge;
  logic [57:0]              sq_trial;
  logic [PROD_W-1:0]        ew_v;

  assign det_ax = hyp ? MUL_W'(ea_x) : MUL_W'(ea_x >>> 4);
  assign det_ay = hyp ? MUL_W'(ea_y) : MUL_W'(ea_y >>> 4);
  assign det_bx = hyp ? MUL_W'(eb_x) : MUL_W'(eb_x >>> 4);
  assign det_by = hyp ? MUL_W'(eb_y) : MUL_W'(eb_y >>> 4);
  assign ref_z  = $signed({2'b00, REF_X[cmd.idx]});
  assign ref_w  = $signed({2'b00, REF_Y[cmd.idx]});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_KSQ0: begin mul_a = MUL_W'(c0x);  mul_b = MUL_W'(c0x); end
      OP_KSQ1: begin mul_a = MUL_W'(c0y);  mul_b = MUL_W'(c0y); end
      OP_DET0: begin mul_a = det_ax;       mul_b = det_by;      end
      OP_DET1: begin mul_a = det_bx;       mul_b = det_ay;      end
      OP_MX0:  begin mul_a = MUL_W'(ea_x); mul_b = ref_z;       end
      OP_MX1:  begin mul_a = MUL_W'(eb_x); mul_b = ref_w;       end
      OP_MY0:  begin mul_a = MUL_W'(ea_y); mul_b = ref_z;       end
      OP_MY1:  begin mul_a = MUL_W'(eb_y); mul_b = ref_w;       end
      OP_NUM: begin
        mul_a = $signed({2'b00, REF_W[cmd.idx]});
        mul_b = $signed({2'b00, area});
      end
      OP_HSQ0: begin mul_a = MUL_W'(x); mul_b = MUL_W'(x); end
      OP_HSQ1: begin mul_a = MUL_W'(y); mul_b = MUL_W'(y); end
      OP_HP: begin
        mul_a = $signed({5'b0, sq_res[28:0]});
        mul_b = $signed({5'b0, tsq[56:28]});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // |det| rounded to Q10.22
  assign det_mag = acc[PROD_W-1] ? PROD_W'(-acc) : PROD_W'(acc);
  assign det_r   = hyp ? ((det_mag + (PROD_W'(1) << 33)) >> 34)
                       : ((det_mag + (PROD_W'(1) << 25)) >> 26);

  assign pt_org = (cmd.op == OP_SETY) ? org_y : org_x;
  assign pt_sum = PROD_W'(pt_org) + ((acc + (PROD_W'(1) << 27)) >>> 28);
  always_comb begin
    if (pt_sum > PROD_W'(64'sh7FFF_FFFF)) pt_clamped = 32'sh7FFF_FFFF;
    else if (pt_sum < -PROD_W'(64'sh8000_0000)) pt_clamped = 32'sh8000_0000;
    else pt_clamped = pt_sum[31:0];
  end

  // Klein conversion: round(p * 2^29 / d)
  assign k_den = 40'(acc[63:28]) + (40'(1) << 28);
  assign k_abs = (cmd.op == OP_KDY_INIT) ? abs33(c0y) : abs33(c0x);
  assign k_num = (64'(k_abs) << 29) + 64'(k_den >> 1);

  // back to the disk: round(k * 2^28 / (2^28 + t))
  assign p_den = (30'(1) << 28) + 30'(sq_res[28:0]);
  assign p_num = (64'((cmd.op == OP_PDY_INIT) ? abs33(y) : abs33(x)) << 28)
                 + 64'(p_den >> 1);

  assign div_r2   = {rem, dlo[31]};
  assign div_ge   = (div_r2 >= {1'b0, dd});
  assign sq_trial = sq_res + 58'(sq_bit);
  assign ew_v     = (PROD_W'(prod) + (PROD_W'(1) << 29)) >> 30;

  assign st.boundary = |acc[PROD_W-1:56];
  assign st.wovf     = (prod[63:0] == 64'd0) || ((num >> 6) >= prod[63:0]);
  assign st.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_KSQ0, OP_DET0, OP_MX0, OP_MY0, OP_NUM, OP_HP: prod <= mul_a * mul_b;
      OP_KSQ1, OP_DET1, OP_MX1, OP_MY1, OP_HSQ1: begin
        acc  <= prod;
        prod <= mul_a * mul_b;
      end
      OP_HSQ0: begin
        num  <= prod[63:0];
        prod <= mul_a * mul_b;
      end
      OP_SUM:  acc <= acc + prod;
      OP_DET2: acc <= acc - prod;
      OP_DET3: area <= (|det_r[PROD_W-1:32]) ? 32'hFFFF_FFFF : det_r[31:0];
      OP_LOAD: begin
        c0x <= s_tdata[31:0];
        c0y <= s_tdata[63:32];
        c1x <= s_tdata[95:64];
        c1y <= s_tdata[127:96];
        c2x <= s_tdata[159:128];
        c2y <= s_tdata[191:160];
      end
      OP_KDX_INIT, OP_KDY_INIT: begin
        rem   <= 64'(k_num[63:32]);
        dlo   <= k_num[31:0];
        dd    <= 64'(k_den);
        dsign <= (cmd.op == OP_KDY_INIT) ? c0y[31] : c0x[31];
        quo   <= '0;
      end
      OP_PDX_INIT, OP_PDY_INIT: begin
        rem   <= 64'(p_num[63:32]);
        dlo   <= p_num[31:0];
        dd    <= 64'(p_den);
        dsign <= (cmd.op == OP_PDY_INIT) ? y[31] : x[31];
        quo   <= '0;
      end
      OP_DW_INIT: begin
        if (st.wovf) begin
          wt  <= 32'hFFFF_FFFF;
          sat <= 1'b1;
        end else begin
          sat <= 1'b0;
        end
        rem <= num >> 6;
        dlo <= {num[5:0], 26'd0};
        dd  <= prod[63:0];
        quo <= '0;
      end
      OP_DIV_STEP: begin
        rem <= div_ge ? div_r2[63:0] - dd : div_r2[63:0];
        quo <= {quo[30:0], div_ge};
        dlo <= {dlo[30:0], 1'b0};
      end
      OP_KDX_END: c0x <= dsign ? -$signed(quo) : $signed(quo);
      OP_KDY_END: begin
        // rotate corners so the next one lands in slot 0
        c0x <= c1x;
        c0y <= c1y;
        c1x <= c2x;
        c1y <= c2y;
        c2x <= c0x;
        c2y <= dsign ? -$signed(quo) : $signed(quo);
      end
      OP_EDGES: begin
        org_x <= c0x;
        org_y <= c0y;
        ea_x  <= EDGE_W'(c1x) - EDGE_W'(c0x);
        ea_y  <= EDGE_W'(c1y) - EDGE_W'(c0y);
        eb_x  <= EDGE_W'(c2x) - EDGE_W'(c0x);
        eb_y  <= EDGE_W'(c2y) - EDGE_W'(c0y);
      end
      OP_SETX: x <= pt_clamped;
      OP_SETY: y <= pt_clamped;
      OP_EW: begin
        if (|ew_v[PROD_W-1:32]) begin
          wt  <= 32'hFFFF_FFFF;
          sat <= 1'b1;
        end else begin
          wt  <= ew_v[31:0];
          sat <= 1'b0;
        end
      end
      OP_HT: begin
        if (st.boundary) begin
          wt  <= 32'hFFFF_FFFF;
          sat <= 1'b1;
        end
        tsq    <= (57'(1) << 56) - acc[56:0];
        sq_v   <= (57'(1) << 56) - acc[56:0];
        sq_res <= '0;
        sq_bit <= 57'(1) << 56;
      end
      OP_SQRT_STEP: begin
        if (58'(sq_v) >= sq_trial) begin
          sq_v   <= sq_v - sq_trial[56:0];
          sq_res <= (sq_res >> 1) + 58'(sq_bit);
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_DW_END:  wt <= quo;
      OP_PDX_END: x <= dsign ? -$signed(quo) : $signed(quo);
      OP_PDY_END: y <= dsign ? -$signed(quo) : $signed(quo);
      OP_OUT: begin
        m_tdata <= {wt, y, x};
        m_tuser <= sat;
        m_tlast <= cmd.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### src/triangle_quadrature_sampler.sv
// Top level of the triangle quadrature sampler: config register, sequencer and datapath.
//
//   channel   dir  words                     handshake
//   s_*       in   one triangle (3 corners)  tvalid/tready
//   m_*       out  one sample per node       tvalid/tready, tlast on final node
//   p*        in   geometry_mode register    APB, pready tied high
//
// Euclidean: a setup phase (accept included), then the per-node steps for each
// of the 36 nodes of a triangle.
// Hyperbolic: corner conversion first, then per node a bit-serial square root
// and up to three 32-step divisions.
// One triangle is in flight at a time; the next is taken once the last word
// sits in the output register. A stalled m_tready holds the sequencer in its
// output step. Reset is synchronous and clears geometry_mode to euclidean.
`timescale 1ns / 1ps
`default_nettype none
module triangle_quadrature_sampler import tqs_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  wire [IN_W-1:0]    s_tdata,   // corner0_x, corner0_y, corner1_x, corner1_y,
                                       // corner2_x, corner2_y
  output logic              m_tvalid,
  input  wire               m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // sample_x, sample_y, weight
  output logic              m_tuser,   // saturated
  output logic              m_tlast,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [CFG_AW-1:0]  paddr,
  input  wire [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic  geometry_mode;
  cmd_t  cmd;
  stat_t st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      geometry_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_GEOMETRY_MODE) begin
      geometry_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_GEOMETRY_MODE) ? CFG_DW'(geometry_mode) : '0;

  tqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .hyp      (geometry_mode),
    .st       (st),
    .cmd      (cmd)
  );

  tqs_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .hyp      (geometry_mode),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

### src/tqs_checker.sv
// Port-level checks for the triangle quadrature sampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tqs_checker import tqs_pkg::*; (
  input wire             clk,
  input wire             rst,
  input wire             s_tvalid,
  input wire             s_tready,
  input wire             m_tvalid,
  input wire             m_tready,
  input wire [OUT_W-1:0] m_tdata,
  input wire             m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while a triangle is in progress");

  a_sat_weight: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[95:64] == 32'hFFFF_FFFF)
    else $error("saturated word without full-scale weight");

endmodule

bind triangle_quadrature_sampler tqs_checker u_tqs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
